// File: hw/rtl/process_run_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef PROCESS_RUN_QUEUE_SCHEDULER_MACROS_SVH
`define PROCESS_RUN_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PSCH_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PSCH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/psch_pkg.sv
// Shared types, sizes and codes of the process run queue scheduler.
package psch_pkg;

  localparam int RUN_DEPTH  = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int RUN_AW     = $clog2(RUN_DEPTH);
  localparam int WAIT_AW    = $clog2(WAIT_DEPTH);
  localparam int RUN_CW     = $clog2(RUN_DEPTH + 1);
  localparam int WAIT_CW    = $clog2(WAIT_DEPTH + 1);
  localparam int IDX_W      = (RUN_CW > WAIT_CW) ? RUN_CW : WAIT_CW;

  // Event kinds.
  localparam logic [2:0] KIND_ARRIVE   = 3'd0;
  localparam logic [2:0] KIND_TICK     = 3'd1;
  localparam logic [2:0] KIND_IO_REQ   = 3'd2;
  localparam logic [2:0] KIND_TERM     = 3'd3;
  localparam logic [2:0] KIND_IO_DONE  = 3'd4;

  // Result status codes.
  localparam logic [3:0] ST_QUEUED     = 4'd0;
  localparam logic [3:0] ST_DISPATCHED = 4'd1;
  localparam logic [3:0] ST_SUSPENDED  = 4'd2;
  localparam logic [3:0] ST_TOWAIT     = 4'd3;
  localparam logic [3:0] ST_ENDED      = 4'd4;
  localparam logic [3:0] ST_RESUMED    = 4'd5;
  localparam logic [3:0] ST_IDLE       = 4'd6;
  localparam logic [3:0] ST_FULL       = 4'd7;
  localparam logic [3:0] ST_MISMATCH   = 4'd8;
  localparam logic [3:0] ST_ABSENT     = 4'd9;

  // Configuration register indexes.
  localparam logic CFG_SCHED_MODE = 1'b0;
  localparam logic CFG_QUANTUM    = 1'b1;

  localparam logic [15:0] QUANTUM_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] proc_id;
    logic [8:0]  proc_priority;
  } psch_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] out_id;
    logic [31:0] response_ticks;
    logic [31:0] turnaround_ticks;
    logic [31:0] waited_ticks;
    logic [15:0] ended_count;
  } psch_out_t;

  // One process record as held in either queue or in the running slot.
  typedef struct packed {
    logic [15:0] id;
    logic [8:0]  prio;
    logic [31:0] arrival;
    logic [31:0] wstart;
    logic [31:0] waited;
    logic [31:0] first;
    logic        seen;
  } psch_entry_t;

endpackage

// File: hw/rtl/psch_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module psch_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
  end

  assign rd = rd_r;

endmodule

// File: hw/rtl/process_run_queue_scheduler.sv
// Run queue scheduler: round robin or priority dispatch over RAM-held queues.
// One event is taken at a time. Arrival, tick while running or idle, I/O
// request, termination and unknown kinds go from decode straight to the
// result stage. A dispatch or an I/O completion walks a queue RAM: a
// search pass (priority mode or completion), then a fetch and a compaction
// pass that moves each later entry one slot down, one RAM read and write
// per cycle. A finished result sits in an output register, and the next
// event is accepted while it waits to be taken.
module process_run_queue_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  psch_pkg::psch_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output psch_pkg::psch_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_GRAB   = 3'd4;
  localparam logic [2:0] S_SHIFT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam int EW = $bits(psch_pkg::psch_entry_t);

  logic [2:0]                      state_r, state_nxt;
  psch_pkg::psch_in_t              ev_r, ev_nxt;
  psch_pkg::psch_out_t             res_r, res_nxt;
  psch_pkg::psch_out_t             out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            mode_r;
  logic [15:0]                     quantum_r;
  logic [psch_pkg::RUN_CW-1:0]     run_cnt_r, run_cnt_nxt;
  logic [psch_pkg::WAIT_CW-1:0]    wait_cnt_r, wait_cnt_nxt;
  logic                            cur_valid_r, cur_valid_nxt;
  psch_pkg::psch_entry_t           cur_r, cur_nxt;
  logic [15:0]                     slice_r, slice_nxt;
  logic [31:0]                     now_r, now_nxt;
  logic [15:0]                     done_r, done_nxt;
  logic                            op_wait_r, op_wait_nxt;
  logic [psch_pkg::IDX_W-1:0]      iss_r, iss_nxt;
  logic [psch_pkg::IDX_W-1:0]      cmpi_r, cmpi_nxt;
  logic                            cmpv_r, cmpv_nxt;
  logic [psch_pkg::IDX_W-1:0]      best_r, best_nxt;
  logic [8:0]                      best_prio_r, best_prio_nxt;
  logic                            found_r, found_nxt;
  psch_pkg::psch_entry_t           hold_r, hold_nxt;

  logic                            run_we, wait_we;
  logic [psch_pkg::RUN_AW-1:0]     run_wa, run_ra;
  logic [psch_pkg::WAIT_AW-1:0]    wait_wa, wait_ra;
  psch_pkg::psch_entry_t           run_wd, wait_wd;
  logic [EW-1:0]                   run_rd_raw, wait_rd_raw;
  psch_pkg::psch_entry_t           q_rd;
  logic [psch_pkg::IDX_W-1:0]      rd_idx, scan_cnt, cmpm1;
  logic                            run_full, wait_full;
  logic [15:0]                     slice_inc;
  logic [31:0]                     now_inc, dwell;
  psch_pkg::psch_entry_t           ent;

  psch_ram #(.DEPTH(psch_pkg::RUN_DEPTH), .WIDTH(EW)) u_run_ram (
    .clk (clk),
    .we  (run_we),
    .wa  (run_wa),
    .wd  (run_wd),
    .ra  (run_ra),
    .rd  (run_rd_raw)
  );

  psch_ram #(.DEPTH(psch_pkg::WAIT_DEPTH), .WIDTH(EW)) u_wait_ram (
    .clk (clk),
    .we  (wait_we),
    .wa  (wait_wa),
    .wd  (wait_wd),
    .ra  (wait_ra),
    .rd  (wait_rd_raw)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // Derived values for the current event.
  assign q_rd      = op_wait_r ? psch_pkg::psch_entry_t'(wait_rd_raw)
                               : psch_pkg::psch_entry_t'(run_rd_raw);
  assign scan_cnt  = op_wait_r ? psch_pkg::IDX_W'(wait_cnt_r) : psch_pkg::IDX_W'(run_cnt_r);
  assign cmpm1     = cmpi_r - psch_pkg::IDX_W'(1);
  assign run_full  = (run_cnt_r == psch_pkg::RUN_CW'(psch_pkg::RUN_DEPTH));
  assign wait_full = (wait_cnt_r == psch_pkg::WAIT_CW'(psch_pkg::WAIT_DEPTH));
  assign slice_inc = (slice_r != 16'hFFFF) ? slice_r + 16'd1 : slice_r;
  assign now_inc   = now_r + 32'd1;
  assign dwell     = now_r - hold_r.wstart;

  // Sequencer: decode, queue search, fetch, compaction and result.
  always_comb begin
    state_nxt     = state_r;
    ev_nxt        = ev_r;
    res_nxt       = res_r;
    run_cnt_nxt   = run_cnt_r;
    wait_cnt_nxt  = wait_cnt_r;
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    slice_nxt     = slice_r;
    now_nxt       = now_r;
    done_nxt      = done_r;
    op_wait_nxt   = op_wait_r;
    iss_nxt       = iss_r;
    cmpi_nxt      = cmpi_r;
    cmpv_nxt      = 1'b0;
    best_nxt      = best_r;
    best_prio_nxt = best_prio_r;
    found_nxt     = found_r;
    hold_nxt      = hold_r;
    rd_idx        = iss_r;
    run_we        = 1'b0;
    wait_we       = 1'b0;
    run_wa        = run_cnt_r[psch_pkg::RUN_AW-1:0];
    wait_wa       = wait_cnt_r[psch_pkg::WAIT_AW-1:0];
    run_wd        = cur_r;
    wait_wd       = cur_r;
    ent           = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    res_nxt.response_ticks   = res_r.response_ticks;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ev_nxt    = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt = '{status: psch_pkg::ST_MISMATCH, out_id: ev_r.proc_id,
                    response_ticks: 32'd0, turnaround_ticks: 32'd0,
                    waited_ticks: 32'd0, ended_count: done_r};
        state_nxt   = S_DONE;
        op_wait_nxt = 1'b0;
        iss_nxt     = '0;
        found_nxt   = 1'b0;
        best_nxt    = '0;
        case (ev_r.kind)
          psch_pkg::KIND_ARRIVE: begin
            if (run_full) begin
              res_nxt.status = psch_pkg::ST_FULL;
            end else begin
              ent = '{id: ev_r.proc_id, prio: ev_r.proc_priority, arrival: now_r,
                      wstart: now_r, waited: 32'd0, first: 32'd0, seen: 1'b0};
              run_we         = 1'b1;
              run_wd         = ent;
              run_cnt_nxt    = run_cnt_r + psch_pkg::RUN_CW'(1);
              res_nxt.status = psch_pkg::ST_QUEUED;
            end
          end
          psch_pkg::KIND_TICK: begin
            now_nxt = now_inc;
            if (cur_valid_r) begin
              res_nxt.out_id = cur_r.id;
              if (slice_inc < quantum_r) begin
                slice_nxt      = slice_inc;
                res_nxt.status = psch_pkg::ST_DISPATCHED;
              end else begin
                cur_valid_nxt = 1'b0;
                slice_nxt     = 16'd0;
                if (run_full) begin
                  res_nxt.status = psch_pkg::ST_FULL;
                end else begin
                  ent            = cur_r;
                  ent.wstart     = now_inc;
                  ent.seen       = 1'b1;
                  run_we         = 1'b1;
                  run_wd         = ent;
                  run_cnt_nxt    = run_cnt_r + psch_pkg::RUN_CW'(1);
                  res_nxt.status = psch_pkg::ST_SUSPENDED;
                end
              end
            end else if (run_cnt_r == '0) begin
              res_nxt.status = psch_pkg::ST_IDLE;
              res_nxt.out_id = 16'd0;
            end else if (mode_r) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          psch_pkg::KIND_IO_REQ, psch_pkg::KIND_TERM: begin
            if (!cur_valid_r) begin
              res_nxt.status = psch_pkg::ST_ABSENT;
            end else if (cur_r.id != ev_r.proc_id) begin
              res_nxt.status = psch_pkg::ST_MISMATCH;
            end else begin
              cur_valid_nxt = 1'b0;
              slice_nxt     = 16'd0;
              if (ev_r.kind == psch_pkg::KIND_IO_REQ) begin
                if (wait_full) begin
                  res_nxt.status = psch_pkg::ST_FULL;
                end else begin
                  ent            = cur_r;
                  ent.seen       = 1'b1;
                  wait_we        = 1'b1;
                  wait_wd        = ent;
                  wait_cnt_nxt   = wait_cnt_r + psch_pkg::WAIT_CW'(1);
                  res_nxt.status = psch_pkg::ST_TOWAIT;
                end
              end else begin
                done_nxt                 = done_r + 16'd1;
                res_nxt.status           = psch_pkg::ST_ENDED;
                res_nxt.response_ticks   = cur_r.first - cur_r.arrival;
                res_nxt.turnaround_ticks = now_r - cur_r.arrival;
                res_nxt.waited_ticks     = cur_r.waited;
                res_nxt.ended_count      = done_r + 16'd1;
              end
            end
          end
          psch_pkg::KIND_IO_DONE: begin
            op_wait_nxt = 1'b1;
            state_nxt   = S_SCAN;
          end
          default: begin
            res_nxt.status = psch_pkg::ST_MISMATCH;
          end
        endcase
      end

      // One read issued per cycle; the entry read in the previous cycle is compared.
      S_SCAN: begin
        if (iss_r < scan_cnt) begin
          rd_idx   = iss_r;
          iss_nxt  = iss_r + psch_pkg::IDX_W'(1);
          cmpv_nxt = 1'b1;
          cmpi_nxt = iss_r;
        end
        if (cmpv_r) begin
          if (op_wait_r) begin
            if (!found_r && q_rd.id == ev_r.proc_id) begin
              found_nxt = 1'b1;
              best_nxt  = cmpi_r;
            end
          end else if (!found_r || q_rd.prio < best_prio_r) begin
            found_nxt     = 1'b1;
            best_nxt      = cmpi_r;
            best_prio_nxt = q_rd.prio;
          end
        end
        if (iss_r == scan_cnt && !cmpv_r) begin
          if (!found_r) begin
            res_nxt.status = psch_pkg::ST_ABSENT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        rd_idx    = best_r;
        state_nxt = S_GRAB;
      end

      S_GRAB: begin
        hold_nxt  = q_rd;
        iss_nxt   = best_r + psch_pkg::IDX_W'(1);
        state_nxt = S_SHIFT;
      end

      // Close the gap: entry i+1 read, written to slot i in the next cycle.
      S_SHIFT: begin
        if (iss_r < scan_cnt) begin
          rd_idx   = iss_r;
          iss_nxt  = iss_r + psch_pkg::IDX_W'(1);
          cmpv_nxt = 1'b1;
          cmpi_nxt = iss_r;
        end
        if (cmpv_r) begin
          if (op_wait_r) begin
            wait_we = 1'b1;
            wait_wa = cmpm1[psch_pkg::WAIT_AW-1:0];
            wait_wd = q_rd;
          end else begin
            run_we = 1'b1;
            run_wa = cmpm1[psch_pkg::RUN_AW-1:0];
            run_wd = q_rd;
          end
        end
        if (iss_r == scan_cnt && !cmpv_r) begin
          if (op_wait_r) begin
            wait_cnt_nxt = wait_cnt_r - psch_pkg::WAIT_CW'(1);
          end else begin
            run_cnt_nxt = run_cnt_r - psch_pkg::RUN_CW'(1);
          end
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        res_nxt.out_id = hold_r.id;
        state_nxt      = S_DONE;
        if (op_wait_r) begin
          if (run_full) begin
            res_nxt.status = psch_pkg::ST_FULL;
          end else begin
            ent            = hold_r;
            ent.wstart     = now_r;
            ent.seen       = 1'b1;
            run_we         = 1'b1;
            run_wd         = ent;
            run_cnt_nxt    = run_cnt_r + psch_pkg::RUN_CW'(1);
            res_nxt.status = psch_pkg::ST_RESUMED;
          end
        end else begin
          ent = hold_r;
          if (!hold_r.seen) begin
            ent.waited = dwell;
            ent.first  = now_r;
          end else begin
            ent.waited = hold_r.waited + dwell;
          end
          cur_nxt        = ent;
          cur_valid_nxt  = 1'b1;
          slice_nxt      = 16'd0;
          res_nxt.status = psch_pkg::ST_DISPATCHED;
        end
      end

      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign run_ra  = rd_idx[psch_pkg::RUN_AW-1:0];
  assign wait_ra = rd_idx[psch_pkg::WAIT_AW-1:0];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      quantum_r   <= psch_pkg::QUANTUM_RESET;
      run_cnt_r   <= '0;
      wait_cnt_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_r       <= '0;
      slice_r     <= 16'd0;
      now_r       <= 32'd0;
      done_r      <= 16'd0;
      cmpv_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_cnt_r   <= run_cnt_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_r       <= cur_nxt;
      slice_r     <= slice_nxt;
      now_r       <= now_nxt;
      done_r      <= done_nxt;
      cmpv_r      <= cmpv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == psch_pkg::CFG_SCHED_MODE) begin
          mode_r <= cfg_data[0];
        end else begin
          quantum_r <= cfg_data;
        end
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    ev_r        <= ev_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
    op_wait_r   <= op_wait_nxt;
    iss_r       <= iss_nxt;
    cmpi_r      <= cmpi_nxt;
    best_r      <= best_nxt;
    best_prio_r <= best_prio_nxt;
    found_r     <= found_nxt;
    hold_r      <= hold_nxt;
  end

endmodule

// File: hw/rtl/psch_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "process_run_queue_scheduler_macros.svh"

module psch_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input psch_pkg::psch_out_t out_data
);

  // A stalled result beat stays offered.
  `PSCH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

  // An accepted event always makes the block busy in the next cycle.
  `PSCH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no busy after beat")

  // Status codes stay within the defined set.
  `PSCH_ASSERT_NOW(a_status_range, out_valid, out_data.status <= psch_pkg::ST_ABSENT, "bad status")

  // An idle result carries no process tag.
  `PSCH_ASSERT_NOW(a_idle_tag, out_valid && out_data.status == psch_pkg::ST_IDLE,
                   out_data.out_id == 16'd0, "idle result with tag")

endmodule

bind process_run_queue_scheduler psch_checker u_psch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: bench/tb_top.sv
// Self-checking testbench of the run queue scheduler with its own event predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  psch_pkg::psch_in_t in_data;
  logic out_valid;
  logic out_stall;
  psch_pkg::psch_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  process_run_queue_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: one process record per queue slot, plus the running slot.
  psch_pkg::psch_entry_t ready_q[$];
  psch_pkg::psch_entry_t io_q[$];
  psch_pkg::psch_entry_t running;
  logic run_busy;
  logic [15:0] slice_cnt;
  logic [31:0] clock_ticks;
  logic [15:0] finished;
  logic pr_mode;
  logic [15:0] pr_quantum;

  psch_pkg::psch_out_t expected_q[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;

  // Directed stimulus rows; check_now marks rows with a typed-in status.
  typedef struct {
    logic [2:0] kind;
    logic [15:0] id;
    logic [8:0] prio;
    logic check_now;
    logic [3:0] status;
  } stim_row_t;

  stim_row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic psch_pkg::psch_out_t make_result(logic [3:0] st, logic [15:0] id,
                                                      logic [31:0] resp, logic [31:0] turn,
                                                      logic [31:0] wt);
    psch_pkg::psch_out_t r;
    r.status = st;
    r.out_id = id;
    r.response_ticks = resp;
    r.turnaround_ticks = turn;
    r.waited_ticks = wt;
    r.ended_count = finished;
    return r;
  endfunction

  // Work out the result of one scheduler event and update the predicted state.
  function automatic psch_pkg::psch_out_t schedule_event(psch_pkg::psch_in_t ev);
    psch_pkg::psch_entry_t e;
    int k;
    int eff_q;
    case (ev.kind)
      psch_pkg::KIND_ARRIVE: begin
        if (ready_q.size() >= psch_pkg::RUN_DEPTH)
          return make_result(psch_pkg::ST_FULL, ev.proc_id, 0, 0, 0);
        e = '0;
        e.id = ev.proc_id;
        e.prio = ev.proc_priority;
        e.arrival = clock_ticks;
        e.wstart = clock_ticks;
        ready_q.push_back(e);
        return make_result(psch_pkg::ST_QUEUED, ev.proc_id, 0, 0, 0);
      end
      psch_pkg::KIND_TICK: begin
        clock_ticks = clock_ticks + 32'd1;
        if (run_busy) begin
          if (slice_cnt != 16'hFFFF) slice_cnt = slice_cnt + 16'd1;
          eff_q = int'(pr_quantum);
          if (int'(slice_cnt) < eff_q)
            return make_result(psch_pkg::ST_DISPATCHED, running.id, 0, 0, 0);
          run_busy = 1'b0;
          slice_cnt = '0;
          e = running;
          e.wstart = clock_ticks;
          e.seen = 1'b1;
          if (ready_q.size() >= psch_pkg::RUN_DEPTH)
            return make_result(psch_pkg::ST_FULL, e.id, 0, 0, 0);
          ready_q.push_back(e);
          return make_result(psch_pkg::ST_SUSPENDED, e.id, 0, 0, 0);
        end
        if (ready_q.size() == 0) return make_result(psch_pkg::ST_IDLE, 16'd0, 0, 0, 0);
        k = 0;
        if (pr_mode) begin
          for (int i = 1; i < ready_q.size(); i++)
            if (ready_q[i].prio < ready_q[k].prio) k = i;
        end
        e = ready_q[k];
        ready_q.delete(k);
        if (!e.seen) begin
          e.waited = '0;
          e.first = clock_ticks;
        end
        e.waited = e.waited + (clock_ticks - e.wstart);
        running = e;
        run_busy = 1'b1;
        slice_cnt = '0;
        return make_result(psch_pkg::ST_DISPATCHED, e.id, 0, 0, 0);
      end
      psch_pkg::KIND_IO_REQ, psch_pkg::KIND_TERM: begin
        if (!run_busy) return make_result(psch_pkg::ST_ABSENT, ev.proc_id, 0, 0, 0);
        if (running.id != ev.proc_id)
          return make_result(psch_pkg::ST_MISMATCH, ev.proc_id, 0, 0, 0);
        run_busy = 1'b0;
        slice_cnt = '0;
        if (ev.kind == psch_pkg::KIND_IO_REQ) begin
          if (io_q.size() >= psch_pkg::WAIT_DEPTH)
            return make_result(psch_pkg::ST_FULL, ev.proc_id, 0, 0, 0);
          e = running;
          e.seen = 1'b1;
          io_q.push_back(e);
          return make_result(psch_pkg::ST_TOWAIT, ev.proc_id, 0, 0, 0);
        end
        finished = finished + 16'd1;
        return make_result(psch_pkg::ST_ENDED, ev.proc_id, running.first - running.arrival,
                           clock_ticks - running.arrival, running.waited);
      end
      psch_pkg::KIND_IO_DONE: begin
        k = -1;
        for (int i = 0; i < io_q.size(); i++)
          if (k < 0 && io_q[i].id == ev.proc_id) k = i;
        if (k < 0) return make_result(psch_pkg::ST_ABSENT, ev.proc_id, 0, 0, 0);
        e = io_q[k];
        io_q.delete(k);
        e.wstart = clock_ticks;
        e.seen = 1'b1;
        if (ready_q.size() >= psch_pkg::RUN_DEPTH)
          return make_result(psch_pkg::ST_FULL, ev.proc_id, 0, 0, 0);
        ready_q.push_back(e);
        return make_result(psch_pkg::ST_RESUMED, ev.proc_id, 0, 0, 0);
      end
      default: return make_result(psch_pkg::ST_MISMATCH, ev.proc_id, 0, 0, 0);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Offer one event and wait for its beat; the expectation is pushed at acceptance.
  // Valid stays high after the beat so that back-to-back events leave no gap; it
  // drops when the sender idles or the stream stops.
  task automatic send_event(logic [2:0] kind, logic [15:0] id, logic [8:0] prio,
                            logic check_now, logic [3:0] status);
    psch_pkg::psch_in_t ev;
    psch_pkg::psch_out_t r;
    ev.kind = kind;
    ev.proc_id = id;
    ev.proc_priority = prio;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = schedule_event(ev);
    if (check_now && r.status != status) report_mismatch("typed status", r.status, status);
    expected_q.push_back(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == psch_pkg::CFG_SCHED_MODE) pr_mode = value[0];
    else pr_quantum = value;
    @(posedge clk);
  endtask

  task automatic add_row(logic [2:0] kind, logic [15:0] id, logic [8:0] prio,
                         logic check_now, logic [3:0] status);
    stim_row_t row;
    row.kind = kind;
    row.id = id;
    row.prio = prio;
    row.check_now = check_now;
    row.status = status;
    rows.push_back(row);
  endtask

  // Random event mix: mostly sensible events on known tags, some noise.
  task automatic random_events(int count);
    logic [2:0] kind;
    logic [15:0] id;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id = 16'($urandom_range(15));
      if (pick < 22) kind = psch_pkg::KIND_ARRIVE;
      else if (pick < 62) kind = psch_pkg::KIND_TICK;
      else if (pick < 74) kind = psch_pkg::KIND_IO_REQ;
      else if (pick < 84) kind = psch_pkg::KIND_TERM;
      else if (pick < 95) kind = psch_pkg::KIND_IO_DONE;
      else kind = 3'($urandom_range(7));
      // Mostly aim requests and completions at the tags that can match.
      if ((kind == psch_pkg::KIND_IO_REQ || kind == psch_pkg::KIND_TERM) && run_busy &&
          $urandom_range(9) < 8)
        id = running.id;
      if (kind == psch_pkg::KIND_IO_DONE && io_q.size() != 0 && $urandom_range(9) < 8)
        id = io_q[$urandom_range(io_q.size() - 1)].id;
      if ($urandom_range(19) == 0) id = 16'($urandom);
      send_event(kind, id, 9'($urandom_range(499)), 1'b0, psch_pkg::ST_QUEUED);
    end
  endtask

  // Result checker: each beat is compared with the oldest expectation.
  always @(posedge clk) begin
    psch_pkg::psch_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result beat, status %0d id %0h", out_data.status, out_data.out_id);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.status != want.status) report_mismatch("status", out_data.status, want.status);
        if (out_data.out_id != want.out_id) report_mismatch("out_id", out_data.out_id, want.out_id);
        if (out_data.response_ticks != want.response_ticks)
          report_mismatch("response_ticks", out_data.response_ticks, want.response_ticks);
        if (out_data.turnaround_ticks != want.turnaround_ticks)
          report_mismatch("turnaround_ticks", out_data.turnaround_ticks, want.turnaround_ticks);
        if (out_data.waited_ticks != want.waited_ticks)
          report_mismatch("waited_ticks", out_data.waited_ticks, want.waited_ticks);
        if (out_data.ended_count != want.ended_count)
          report_mismatch("ended_count", out_data.ended_count, want.ended_count);
      end
    end
  end

  // Receiver stall: random, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = psch_pkg::CFG_SCHED_MODE;
    cfg_data = '0;
    pr_mode = 1'b0;
    pr_quantum = psch_pkg::QUANTUM_RESET;
    run_busy = 1'b0;
    running = '0;
    slice_cnt = '0;
    clock_ticks = '0;
    finished = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings, then priority mode with quantum zero.
    add_row(psch_pkg::KIND_TICK, 16'h0000, 9'd0, 1'b1, psch_pkg::ST_IDLE);
    add_row(psch_pkg::KIND_TERM, 16'h0005, 9'd0, 1'b1, psch_pkg::ST_ABSENT);
    add_row(psch_pkg::KIND_IO_DONE, 16'h0007, 9'd0, 1'b1, psch_pkg::ST_ABSENT);
    add_row(psch_pkg::KIND_ARRIVE, 16'hFFFF, 9'd499, 1'b1, psch_pkg::ST_QUEUED);
    add_row(psch_pkg::KIND_ARRIVE, 16'h0000, 9'd0, 1'b1, psch_pkg::ST_QUEUED);
    add_row(psch_pkg::KIND_TICK, 16'h1234, 9'd0, 1'b1, psch_pkg::ST_DISPATCHED);
    add_row(psch_pkg::KIND_TICK, 16'h0000, 9'd0, 1'b1, psch_pkg::ST_DISPATCHED);
    add_row(psch_pkg::KIND_TERM, 16'h0001, 9'd0, 1'b1, psch_pkg::ST_MISMATCH);
    add_row(psch_pkg::KIND_IO_REQ, 16'hFFFF, 9'd0, 1'b1, psch_pkg::ST_TOWAIT);
    add_row(3'd5, 16'hAAAA, 9'h1FF, 1'b1, psch_pkg::ST_MISMATCH);
    add_row(3'd7, 16'h5555, 9'd0, 1'b1, psch_pkg::ST_MISMATCH);
    add_row(psch_pkg::KIND_IO_DONE, 16'hFFFF, 9'd0, 1'b1, psch_pkg::ST_RESUMED);
    add_row(psch_pkg::KIND_TICK, 16'h0000, 9'd0, 1'b1, psch_pkg::ST_DISPATCHED);
    add_row(psch_pkg::KIND_TICK, 16'h0000, 9'd0, 1'b0, psch_pkg::ST_QUEUED);
    add_row(psch_pkg::KIND_TERM, 16'h0000, 9'd0, 1'b0, psch_pkg::ST_QUEUED);
    add_row(psch_pkg::KIND_TICK, 16'h0000, 9'd0, 1'b0, psch_pkg::ST_QUEUED);
    add_row(psch_pkg::KIND_TERM, 16'hFFFF, 9'd0, 1'b0, psch_pkg::ST_QUEUED);
    foreach (rows[i]) send_event(rows[i].kind, rows[i].id, rows[i].prio,
                                 rows[i].check_now, rows[i].status);
    drain_results();

    // Fill the run queue past its depth, with the receiver held off meanwhile.
    write_reg(psch_pkg::CFG_SCHED_MODE, 16'd1);
    write_reg(psch_pkg::CFG_QUANTUM, 16'd0);
    hold_off <= 300;
    for (int i = 0; i < psch_pkg::RUN_DEPTH + 2; i++)
      send_event(psch_pkg::KIND_ARRIVE, 16'(i), 9'($urandom_range(499)),
                 i >= psch_pkg::RUN_DEPTH, psch_pkg::ST_FULL);
    send_event(psch_pkg::KIND_TICK, 16'd0, 9'd0, 1'b1, psch_pkg::ST_DISPATCHED);
    send_event(psch_pkg::KIND_TICK, 16'd0, 9'd0, 1'b1, psch_pkg::ST_SUSPENDED);
    drain_results();

    // Random phases over several settings and idling profiles.
    send_idle_pct = 19;
    recv_idle_pct = 80;
    write_reg(psch_pkg::CFG_QUANTUM, 16'd3);
    random_events(300);
    drain_results();
    send_idle_pct = 80;
    recv_idle_pct = 19;
    write_reg(psch_pkg::CFG_SCHED_MODE, 16'd0);
    write_reg(psch_pkg::CFG_QUANTUM, 16'd1);
    random_events(300);
    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(psch_pkg::CFG_SCHED_MODE, 16'd1);
    write_reg(psch_pkg::CFG_QUANTUM, 16'hFFFF);
    random_events(150);
    drain_results();
    write_reg(psch_pkg::CFG_QUANTUM, 16'd2);
    random_events(250);
    drain_results();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
